>>> design/sicxe_pd_pkg.sv
// shared types, constants and opcode classification for the sic/xe predecoder
// no dependencies; imported by every module of the block
package sicxe_pd_pkg;

  localparam int ADDR_BITS = 20;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef logic [ADDR_BITS-1:0] addr_t;

  localparam logic [7:0] OP_LDB   = 8'h68;
  localparam logic [7:0] OP_SVC   = 8'hB0;
  localparam logic [7:0] OP_CLEAR = 8'hB4;
  localparam logic [7:0] OP_TIXR  = 8'hB8;

  localparam logic [2:0] FMT_1 = 3'd1;
  localparam logic [2:0] FMT_2 = 3'd2;
  localparam logic [2:0] FMT_3 = 3'd3;
  localparam logic [2:0] FMT_4 = 3'd4;

  typedef enum logic [1:0] {
    CLS_FMT1,
    CLS_FMT2,
    CLS_FMT34,
    CLS_UNKNOWN
  } op_class_t;

  // instruction handed from front to back
  typedef struct packed {
    addr_t       loc;
    logic [31:0] word;
    logic [2:0]  len;
    logic        unknown;
  } pd_item_t;

  typedef struct packed {
    logic [19:0] location;
    logic [7:0]  opcode;
    logic [2:0]  format;
    logic [5:0]  flags;
    logic [3:0]  reg_first;
    logic [3:0]  reg_second;
    logic [19:0] address_field;
    logic [19:0] target_address;
    logic [19:0] base_value;
    logic        unknown_opcode;
  } pd_result_t;

  function automatic op_class_t classify(input logic [7:0] b);
    op_class_t   c;
    logic [7:0]  top6;
    top6 = {b[7:2], 2'b00};
    case (b) inside
      8'hC0, 8'hC4, 8'hC8, 8'hF0, 8'hF4, 8'hF8: c = CLS_FMT1;
      8'h90, 8'h94, 8'h98, 8'h9C, 8'hA0, 8'hA4,
      8'hA8, 8'hAC, 8'hB0, 8'hB4, 8'hB8:        c = CLS_FMT2;
      default: begin
        case (top6) inside
          [8'h00:8'h88], 8'hD0, 8'hD4, 8'hD8, 8'hDC,
          8'hE0, 8'hE8, 8'hEC:                  c = CLS_FMT34;
          default:                              c = CLS_UNKNOWN;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic addr_t to_addr(input logic [19:0] v);
    logic [31:0] t;
    t = 32'(v);
    return t[ADDR_BITS-1:0];
  endfunction

  function automatic logic [19:0] from_addr(input addr_t a);
    logic [31:0] t;
    t = 32'(a);
    return t[19:0];
  endfunction

endpackage

>>> design/sicxe_pd_front.sv
// front end: gathers object-code bytes into whole instructions, tracks location
// depends on sicxe_pd_pkg; pushes one item per instruction into the queue
module sicxe_pd_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             code_byte,
  input  logic                   record_start,
  input  logic [19:0]            record_address,
  input  logic                   q_full,
  output logic                   push,
  output sicxe_pd_pkg::pd_item_t push_item
);
  import sicxe_pd_pkg::*;

  addr_t       loc, loc_next;
  logic [23:0] buffer, buffer_next;
  logic [1:0]  held, held_next;
  logic [2:0]  exp_len, exp_len_next;

  addr_t       loc_eff;
  logic [23:0] buffer_eff;
  logic [1:0]  held_eff;
  logic [2:0]  exp_eff;
  logic [2:0]  count;
  logic [2:0]  exp_upd;
  logic [31:0] joined;
  logic        accept;
  op_class_t   cls;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign cls      = classify(code_byte);

  always_comb begin
    loc_eff    = record_start ? to_addr(record_address) : loc;
    buffer_eff = record_start ? 24'd0 : buffer;
    held_eff   = record_start ? 2'd0 : held;
    exp_eff    = record_start ? 3'd0 : exp_len;
    count      = {1'b0, held_eff} + 3'd1;
    joined     = {buffer_eff, code_byte};
    exp_upd    = exp_eff;
    if (count == 3'd2 && exp_eff == 3'd3 && buffer_eff[1:0] != 2'b00 && code_byte[4]) begin
      exp_upd = 3'd4;
    end

    loc_next     = loc;
    buffer_next  = buffer;
    held_next    = held;
    exp_len_next = exp_len;
    push         = 1'b0;
    push_item    = '{loc: loc_eff, word: {code_byte, 24'd0}, len: 3'd1, unknown: 1'b0};

    if (accept) begin
      loc_next     = loc_eff;
      buffer_next  = buffer_eff;
      held_next    = held_eff;
      exp_len_next = exp_eff;
      if (held_eff == 2'd0 || exp_eff < 3'd2) begin
        unique case (cls)
          CLS_FMT1, CLS_UNKNOWN: begin
            push              = 1'b1;
            push_item.unknown = (cls == CLS_UNKNOWN);
            loc_next          = loc_eff + addr_t'(1);
            held_next         = 2'd0;
            exp_len_next      = 3'd0;
          end
          CLS_FMT2: begin
            buffer_next  = {16'd0, code_byte};
            held_next    = 2'd1;
            exp_len_next = 3'd2;
          end
          CLS_FMT34: begin
            buffer_next  = {16'd0, code_byte};
            held_next    = 2'd1;
            exp_len_next = 3'd3;
          end
          default: begin
          end
        endcase
      end else if (count >= exp_upd) begin
        push           = 1'b1;
        push_item.len  = count;
        case (count)
          3'd2:    push_item.word = joined << 16;
          3'd3:    push_item.word = joined << 8;
          default: push_item.word = joined;
        endcase
        loc_next     = loc_eff + addr_t'(count);
        buffer_next  = 24'd0;
        held_next    = 2'd0;
        exp_len_next = 3'd0;
      end else begin
        buffer_next  = {buffer_eff[15:0], code_byte};
        held_next    = count[1:0];
        exp_len_next = exp_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loc     <= '0;
      buffer  <= '0;
      held    <= '0;
      exp_len <= '0;
    end else begin
      loc     <= loc_next;
      buffer  <= buffer_next;
      held    <= held_next;
      exp_len <= exp_len_next;
    end
  end

endmodule

>>> design/sicxe_pd_queue.sv
// short fifo between the byte-gathering front and the decoding back
// depends on sicxe_pd_pkg for the item type and depth
module sicxe_pd_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  sicxe_pd_pkg::pd_item_t push_item,
  output logic                   full,
  input  logic                   pop,
  output logic                   empty,
  output sicxe_pd_pkg::pd_item_t head_item
);
  import sicxe_pd_pkg::*;

  pd_item_t                  entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] fill;

  assign full      = (fill == QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign empty     = (fill == '0);
  assign head_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> design/sicxe_pd_back.sv
// back end: decodes queued instructions, forms target address, keeps base register
// depends on sicxe_pd_pkg; drives the registered result transaction
module sicxe_pd_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_empty,
  input  sicxe_pd_pkg::pd_item_t   head_item,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output sicxe_pd_pkg::pd_result_t result
);
  import sicxe_pd_pkg::*;

  addr_t       base, base_next;
  pd_result_t  res_next;

  logic [7:0]  b0, b1, b2, b3;
  logic [1:0]  ni;
  logic [5:0]  flg;
  logic [19:0] field;
  addr_t       target;
  addr_t       disp_ext;

  assign pop = !q_empty && (!out_valid || !out_stall);
  assign b0  = head_item.word[31:24];
  assign b1  = head_item.word[23:16];
  assign b2  = head_item.word[15:8];
  assign b3  = head_item.word[7:0];
  assign ni  = b0[1:0];

  always_comb begin
    base_next = base;
    flg       = '0;
    field     = '0;
    target    = '0;
    disp_ext  = {{(ADDR_BITS-12){b1[3]}}, b1[3:0], b2};
    res_next  = '0;
    res_next.location = from_addr(head_item.loc);
    res_next.format   = head_item.len;

    case (head_item.len)
      FMT_1: begin
        res_next.opcode         = b0;
        res_next.unknown_opcode = head_item.unknown;
      end
      FMT_2: begin
        res_next.opcode     = b0;
        res_next.reg_first  = b1[7:4];
        res_next.reg_second = (b0 == OP_SVC || b0 == OP_CLEAR || b0 == OP_TIXR) ?
                              4'd0 : b1[3:0];
      end
      default: begin
        res_next.opcode = {b0[7:2], 2'b00};
        if (ni == 2'b00) begin
          flg    = {2'b00, b1[7], 3'b000};
          field  = {5'd0, b1[6:0], b2};
          target = to_addr(field);
        end else begin
          flg = {ni, b1[7:4]};
          if (head_item.len == FMT_4) begin
            field  = {b1[3:0], b2, b3};
            target = to_addr(field);
          end else begin
            field = {8'd0, b1[3:0], b2};
            if (flg[1]) begin
              target = head_item.loc + addr_t'(3) + disp_ext;
            end else if (flg[2]) begin
              target = base + to_addr(field);
            end else begin
              target = to_addr(field);
            end
          end
          if (res_next.opcode == OP_LDB && ni[0]) begin
            base_next = target;
          end
        end
        res_next.flags          = flg;
        res_next.address_field  = field;
        res_next.target_address = from_addr(target);
      end
    endcase
    res_next.base_value = from_addr(base_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      base      <= '0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        base      <= base_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= res_next;
    end
  end

endmodule

>>> design/sicxe_instruction_predecoder_core.sv
// top level of the sic/xe instruction predecoder
// depends on sicxe_pd_pkg, sicxe_pd_front, sicxe_pd_queue, sicxe_pd_back
//
// usage
//   input channel: one object-code byte per transaction (in_valid / in_stall),
//   with record_start marking the first byte of a text record and
//   record_address giving its load address. a partly gathered instruction is
//   dropped when a new record starts.
//   output channel: one transaction per complete instruction (out_valid /
//   out_stall) with location, opcode, format, nixbpe flags, format 2 registers,
//   raw address field, target address, base register and an unknown-opcode bit.
//   throughput: one byte per cycle, sustained while the receiver keeps up.
//   the result of an instruction is registered first into a queue entry, then
//   passes through the decode stage into the output register.
//   the four-entry queue between front and back lets the byte side keep
//   running while the receiver stalls; in_stall rises only when it is full.
//   the output register holds its transaction stable while out_stall is high.
//   reset (rst, synchronous) clears the location counter, base register,
//   byte gathering state, queue and output valid.
module sicxe_instruction_predecoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  code_byte,
  input  logic        record_start,
  input  logic [19:0] record_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [19:0] location,
  output logic [7:0]  opcode,
  output logic [2:0]  format,
  output logic [5:0]  flags,
  output logic [3:0]  reg_first,
  output logic [3:0]  reg_second,
  output logic [19:0] address_field,
  output logic [19:0] target_address,
  output logic [19:0] base_value,
  output logic        unknown_opcode
);
  import sicxe_pd_pkg::*;

  logic       push, pop, q_full, q_empty;
  pd_item_t   push_item, head_item;
  pd_result_t result;

  sicxe_pd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .code_byte      (code_byte),
    .record_start   (record_start),
    .record_address (record_address),
    .q_full         (q_full),
    .push           (push),
    .push_item      (push_item)
  );

  sicxe_pd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head_item (head_item)
  );

  sicxe_pd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head_item (head_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  assign location       = result.location;
  assign opcode         = result.opcode;
  assign format         = result.format;
  assign flags          = result.flags;
  assign reg_first      = result.reg_first;
  assign reg_second     = result.reg_second;
  assign address_field  = result.address_field;
  assign target_address = result.target_address;
  assign base_value     = result.base_value;
  assign unknown_opcode = result.unknown_opcode;

endmodule

>>> design/sicxe_pd_checker.sv
// port-level checks for the sic/xe predecoder, bound to the top level
// depends on sicxe_pd_pkg and sicxe_instruction_predecoder_core
module sicxe_pd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [19:0] location,
  input logic [2:0]  format,
  input logic [5:0]  flags,
  input logic [3:0]  reg_first,
  input logic [3:0]  reg_second,
  input logic [19:0] address_field,
  input logic [19:0] target_address,
  input logic        unknown_opcode
);
  import sicxe_pd_pkg::*;

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(location) && $stable(format))
    else $error("stalled output transaction changed");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_short_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (format == FMT_1 || format == FMT_2) |->
      flags == 6'd0 && address_field == 20'd0 && target_address == 20'd0)
    else $error("format 1/2 transaction carries address fields");

  a_regs_only_fmt2: assert property (@(posedge clk) disable iff (rst)
    out_valid && format != FMT_2 |-> reg_first == 4'd0 && reg_second == 4'd0)
    else $error("register operands outside format 2");

  a_unknown_fmt1: assert property (@(posedge clk) disable iff (rst)
    out_valid && unknown_opcode |-> format == FMT_1 && flags == 6'd0)
    else $error("unknown opcode not reported as one-byte item");

endmodule

bind sicxe_instruction_predecoder_core sicxe_pd_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .location       (location),
  .format         (format),
  .flags          (flags),
  .reg_first      (reg_first),
  .reg_second     (reg_second),
  .address_field  (address_field),
  .target_address (target_address),
  .unknown_opcode (unknown_opcode)
);

>>> tb/sv/tb_sicxe_instruction_predecoder_core.sv
// self-checking testbench for the sic/xe instruction predecoder core
// depends on sicxe_pd_pkg and sicxe_instruction_predecoder_core; byte stream in, decoded
// instructions out, each checked against a built-in decoder model
`timescale 1ns / 1ps

module tb_sicxe_instruction_predecoder_core;
  import sicxe_pd_pkg::*;

  typedef struct {
    logic [7:0]  code;
    logic        rs;
    logic [19:0] raddr;
    bit          drain;
  } byte_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  code_byte = 8'd0;
  logic        record_start = 1'b0;
  logic [19:0] record_address = 20'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [19:0] location;
  logic [7:0]  opcode;
  logic [2:0]  format;
  logic [5:0]  flags;
  logic [3:0]  reg_first;
  logic [3:0]  reg_second;
  logic [19:0] address_field;
  logic [19:0] target_address;
  logic [19:0] base_value;
  logic        unknown_opcode;

  sicxe_instruction_predecoder_core u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .code_byte(code_byte),
    .record_start(record_start),
    .record_address(record_address),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .location(location),
    .opcode(opcode),
    .format(format),
    .flags(flags),
    .reg_first(reg_first),
    .reg_second(reg_second),
    .address_field(address_field),
    .target_address(target_address),
    .base_value(base_value),
    .unknown_opcode(unknown_opcode)
  );

  logic [7:0] fmt1_ops [6] = '{8'hC0, 8'hC4, 8'hC8, 8'hF0, 8'hF4, 8'hF8};
  logic [7:0] fmt2_ops [11] = '{8'h90, 8'h94, 8'h98, 8'h9C, 8'hA0, 8'hA4,
                                8'hA8, 8'hAC, 8'hB0, 8'hB4, 8'hB8};
  logic [7:0] fmt34_ops [42] = '{
    8'h00, 8'h04, 8'h08, 8'h0C, 8'h10, 8'h14, 8'h18, 8'h1C, 8'h20, 8'h24, 8'h28,
    8'h2C, 8'h30, 8'h34, 8'h38, 8'h3C, 8'h40, 8'h44, 8'h48, 8'h4C, 8'h50, 8'h54,
    8'h58, 8'h5C, 8'h60, 8'h64, 8'h68, 8'h6C, 8'h70, 8'h74, 8'h78, 8'h7C, 8'h80,
    8'h84, 8'h88, 8'hD0, 8'hD4, 8'hD8, 8'hDC, 8'hE0, 8'hE8, 8'hEC};

  byte_item_t byte_q[$];
  pd_result_t decoded_q[$];

  // decoder model state
  logic [31:0] loc_ctr = 32'd0;
  logic [31:0] base_reg = 32'd0;
  logic [23:0] gather = 24'd0;
  int          held = 0;
  int          want_len = 0;

  int  mismatches = 0;
  int  n_taken = 0;
  int  n_results = 0;
  bit  in_taken = 1'b0;
  bit  out_taken = 1'b0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  int  holds_done = 0;

  function automatic bit in_fmt1(input logic [7:0] b);
    foreach (fmt1_ops[k]) if (fmt1_ops[k] == b) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit in_fmt2(input logic [7:0] b);
    foreach (fmt2_ops[k]) if (fmt2_ops[k] == b) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit in_fmt34(input logic [7:0] b);
    foreach (fmt34_ops[k]) if (fmt34_ops[k] == {b[7:2], 2'b00}) return 1'b1;
    return 1'b0;
  endfunction

  task automatic track_byte(input logic [7:0] b, input logic rs, input logic [19:0] ra);
    logic [31:0] w, field, target, amask;
    logic [7:0]  b0, b1, b2, b3;
    logic [5:0]  fl;
    int          cnt;
    pd_result_t  r;
    amask = (32'd1 << ADDR_BITS) - 32'd1;
    if (rs) begin
      loc_ctr = {12'd0, ra} & amask;
      held = 0;
      want_len = 0;
      gather = '0;
    end
    if (held == 0 || want_len < 2) begin
      if (in_fmt1(b) || !(in_fmt2(b) || in_fmt34(b))) begin
        r = '0;
        r.location = loc_ctr[19:0];
        r.opcode = b;
        r.format = FMT_1;
        r.base_value = base_reg[19:0];
        r.unknown_opcode = !in_fmt1(b);
        decoded_q = {decoded_q, r};
        loc_ctr = (loc_ctr + 32'd1) & amask;
        held = 0;
        want_len = 0;
        return;
      end
      want_len = in_fmt2(b) ? 2 : 3;
      gather = {16'd0, b};
      held = 1;
      return;
    end
    cnt = held + 1;
    // e flag on the second byte stretches format 3 to format 4
    if (cnt == 2 && want_len == 3 && gather[1:0] != 2'b00 && b[4]) want_len = 4;
    if (cnt < want_len) begin
      gather = {gather[15:0], b};
      held = cnt;
      return;
    end
    w = {gather, b} << (8 * (4 - cnt));
    b0 = w[31:24];
    b1 = w[23:16];
    b2 = w[15:8];
    b3 = w[7:0];
    r = '0;
    r.location = loc_ctr[19:0];
    if (cnt == 2) begin
      r.opcode = b0;
      r.format = FMT_2;
      r.reg_first = b1[7:4];
      if (b0 == OP_SVC || b0 == OP_CLEAR || b0 == OP_TIXR) r.reg_second = 4'd0;
      else r.reg_second = b1[3:0];
    end else begin
      if (b0[1:0] == 2'b00) begin
        // sic form: only x is meaningful, 15-bit address
        fl = {2'b00, b1[7], 3'b000};
        field = {17'd0, b1[6:0], b2};
        target = field & amask;
      end else begin
        fl = {b0[1:0], b1[7:4]};
        if (cnt == 4) begin
          field = {12'd0, b1[3:0], b2, b3};
          target = field & amask;
        end else begin
          field = {20'd0, b1[3:0], b2};
          if (fl[1]) target = (loc_ctr + 32'd3 + {{20{field[11]}}, field[11:0]}) & amask;
          else if (fl[2]) target = (base_reg + field) & amask;
          else target = field & amask;
        end
        if ({b0[7:2], 2'b00} == OP_LDB && b0[0]) base_reg = target;
      end
      r.opcode = {b0[7:2], 2'b00};
      r.format = (cnt == 4) ? FMT_4 : FMT_3;
      r.flags = fl;
      r.address_field = field[19:0];
      r.target_address = target[19:0];
    end
    r.base_value = base_reg[19:0];
    decoded_q = {decoded_q, r};
    loc_ctr = (loc_ctr + cnt) & amask;
    held = 0;
    want_len = 0;
    gather = '0;
  endtask

  function automatic void check_field(input string fname, input logic [19:0] want,
                                      input logic [19:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s at result %0d: expected %h, got %h",
                 fname, n_results, want, got);
    end
  endfunction

  function automatic logic [19:0] rand_addr();
    if ($urandom_range(0, 7) == 0) return 20'hFFFF0 | 20'($urandom_range(0, 15));
    return 20'($urandom);
  endfunction

  task automatic queue_byte(input logic [7:0] code, input logic rs, input logic [19:0] ra);
    byte_item_t it;
    it.code = code;
    it.rs = rs;
    it.raddr = ra;
    it.drain = 1'b0;
    byte_q = {byte_q, it};
  endtask

  task automatic add_random_instr();
    int         kind;
    logic [7:0] op, b1, b2;
    logic       rs;
    kind = $urandom_range(0, 99);
    rs = ($urandom_range(0, 29) == 0);
    if (kind < 8) begin
      queue_byte(fmt1_ops[$urandom_range(0, 5)], rs, rand_addr());
    end else if (kind < 22) begin
      queue_byte(fmt2_ops[$urandom_range(0, 10)], rs, rand_addr());
      queue_byte(8'($urandom), $urandom_range(0, 39) == 0, rand_addr());
    end else if (kind < 80) begin
      op = fmt34_ops[$urandom_range(0, 41)];
      if ($urandom_range(0, 6) == 0) op = OP_LDB;
      op[1:0] = 2'($urandom_range(0, 3));
      b1 = 8'($urandom);
      b2 = 8'($urandom);
      queue_byte(op, rs, rand_addr());
      queue_byte(b1, $urandom_range(0, 39) == 0, rand_addr());
      queue_byte(b2, $urandom_range(0, 39) == 0, rand_addr());
      if (op[1:0] != 2'b00 && b1[4])
        queue_byte(8'($urandom), $urandom_range(0, 39) == 0, rand_addr());
    end else if (kind < 90) begin
      op = 8'($urandom);
      while (in_fmt1(op) || in_fmt2(op) || in_fmt34(op)) op = 8'($urandom);
      queue_byte(op, rs, rand_addr());
    end else begin
      queue_byte(8'($urandom), rs, rand_addr());
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // input driver
  always @(negedge clk) begin : drive_in
    logic       nv;
    byte_item_t nxt;
    nv = in_valid;
    if (rst) begin
      nv = 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_taken) begin
        nv = 1'b0;
        gap_left = ((n_taken / 150) % 4 == 3) ? 0 : $urandom_range(0, 4);
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (byte_q.size() != 0 && !(byte_q[0].drain && decoded_q.size() != 0)) begin
          nxt = byte_q.pop_front();
          code_byte <= nxt.code;
          record_start <= nxt.rs;
          record_address <= nxt.raddr;
          nv = 1'b1;
        end
      end
    end
    in_valid <= nv;
  end

  // output receiver
  always @(negedge clk) begin : drive_out
    if (rst) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_taken) stall_left = ((n_results / 60) % 4 == 2) ? 0 : $urandom_range(0, 4);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // long receiver hold-off so the internal queue fills and backpressures
  always @(posedge clk) begin : long_hold
    if (hold_left > 0) begin
      hold_left--;
    end else if (!rst && holds_done < 2 && n_results >= (holds_done + 1) * 150) begin
      hold_left = 80;
      holds_done++;
    end
  end

  always @(posedge clk) begin : monitor
    pd_result_t want;
    in_taken = 1'b0;
    out_taken = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        track_byte(code_byte, record_start, record_address);
        in_taken = 1'b1;
        n_taken++;
      end
      if (out_valid && !out_stall) begin
        out_taken = 1'b1;
        if (decoded_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transaction at location %h, opcode %h", location, opcode);
        end else begin
          want = decoded_q.pop_front();
          check_field("location", want.location, location);
          check_field("opcode", want.opcode, opcode);
          check_field("format", want.format, format);
          check_field("flags", want.flags, flags);
          check_field("reg_first", want.reg_first, reg_first);
          check_field("reg_second", want.reg_second, reg_second);
          check_field("address_field", want.address_field, address_field);
          check_field("target_address", want.target_address, target_address);
          check_field("base_value", want.base_value, base_value);
          check_field("unknown_opcode", want.unknown_opcode, unknown_opcode);
        end
        n_results++;
      end
    end
  end

  initial begin
    int directed_len;
    // fmt1 near the top of memory so the location counter wraps
    queue_byte(8'hC4, 1'b1, 20'hFFFFE);
    // clear: second register forced to zero
    queue_byte(OP_CLEAR, 1'b0, 20'($urandom));
    queue_byte(8'h5F, 1'b0, 20'($urandom));
    // ldb immediate loads the base register
    queue_byte(OP_LDB | 8'h01, 1'b0, 20'($urandom));
    queue_byte(8'h01, 1'b0, 20'($urandom));
    queue_byte(8'h23, 1'b0, 20'($urandom));
    // pc-relative, negative displacement
    queue_byte(8'h4B, 1'b0, 20'($urandom));
    queue_byte(8'h2F, 1'b0, 20'($urandom));
    queue_byte(8'hF0, 1'b0, 20'($urandom));
    // base-relative, maximum displacement
    queue_byte(8'h03, 1'b0, 20'($urandom));
    queue_byte(8'h4F, 1'b0, 20'($urandom));
    queue_byte(8'hFF, 1'b0, 20'($urandom));
    // b and p both set
    queue_byte(8'h1B, 1'b0, 20'($urandom));
    queue_byte(8'h6A, 1'b0, 20'($urandom));
    queue_byte(8'h00, 1'b0, 20'($urandom));
    // format 4 with x, full address
    queue_byte(8'h77, 1'b0, 20'($urandom));
    queue_byte(8'h9F, 1'b0, 20'($urandom));
    queue_byte(8'hFF, 1'b0, 20'($urandom));
    queue_byte(8'hFF, 1'b0, 20'($urandom));
    // sic form with x
    queue_byte(8'h00, 1'b0, 20'($urandom));
    queue_byte(8'hFF, 1'b0, 20'($urandom));
    queue_byte(8'hFF, 1'b0, 20'($urandom));
    // unknown opcode
    queue_byte(8'hFF, 1'b0, 20'($urandom));
    // partial ldb dropped by a new record
    queue_byte(OP_LDB | 8'h02, 1'b0, 20'($urandom));
    queue_byte(8'h10, 1'b0, 20'($urandom));
    queue_byte(8'hC0, 1'b1, 20'h00000);
    directed_len = byte_q.size();
    while (byte_q.size() < directed_len + 1200) add_random_instr();
    // sender waits for all results before these transactions
    byte_q[directed_len].drain = 1'b1;
    byte_q[directed_len + 600].drain = 1'b1;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (byte_q.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
